>>> rtl/frt_pkg.sv
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and constants for the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int MSG_ID_W        = 64;
  localparam int ID_BYTES_DEF    = 8;
  localparam int FIELD_W         = 16;
  localparam int FRAG_W          = 8;

  localparam logic [FRAG_W-1:0]  MAX_FRAGMENTS_RST = 8'd8;
  localparam logic [FIELD_W-1:0] MAX_BUFFER_RST    = 16'(8 * 1024);

  typedef enum logic [2:0] {
    VERDICT_SINGLE   = 3'd0,
    VERDICT_STORED   = 3'd1,
    VERDICT_COMPLETE = 3'd2,
    VERDICT_BAD_HDR  = 3'd3,
    VERDICT_MISMATCH = 3'd4,
    VERDICT_OVERFLOW = 3'd5
  } verdict_t;

  typedef enum logic [0:0] {
    CFG_MAX_FRAGMENTS = 1'b0,
    CFG_MAX_BUFFER    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [FIELD_W-1:0] write_offset;
    logic [FIELD_W-1:0] message_length;
    logic               dropped_partial;
  } result_t;

endpackage

>>> rtl/fragment_reassembly_tracker_top.sv
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_top
// In-order fragment reassembly bookkeeping for one partial message at a time.
// ----------------------------------------------------------------------------
// Each input word is one decoded fragment header. The block checks it against
// the partial message in progress, updates the partial and returns one result
// word with a verdict, the buffer offset for the chunk, the completed length
// and a flag for a discarded partial. A header is taken in every cycle while
// input ready is high: the whole check and state update is one pass of logic
// from the input ports into the partial-message registers and the result or
// skid register. A two-entry output stage (result register plus skid
// register) keeps input ready high while one result waits;
// input ready drops only when both entries are full. Configuration writes
// take effect at the next clock edge and should be made while the block is
// idle.
module fragment_reassembly_tracker_top #(
  parameter int ID_BYTES = frt_pkg::ID_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  frt_pkg::cfg_reg_t                    cfg_index,
  input  logic [frt_pkg::FIELD_W-1:0]          cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [frt_pkg::MSG_ID_W-1:0]         in_message_id,
  input  logic signed [frt_pkg::FIELD_W-1:0]   in_fragment_index,
  input  logic signed [frt_pkg::FIELD_W-1:0]   in_fragment_total,
  input  logic [frt_pkg::FIELD_W-1:0]          in_chunk_length,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output frt_pkg::verdict_t                    out_verdict,
  output logic [frt_pkg::FIELD_W-1:0]          out_write_offset,
  output logic [frt_pkg::FIELD_W-1:0]          out_message_length,
  output logic                                 out_dropped_partial
);
  import frt_pkg::*;

  localparam int ID_W = 8 * ID_BYTES;

  logic [FRAG_W-1:0]  max_frag_r;
  logic [FIELD_W-1:0] max_buf_r;

  logic [ID_W-1:0]    partial_id_r,       partial_id_nxt;
  logic [FRAG_W-1:0]  partial_total_r,    partial_total_nxt;
  logic [FRAG_W-1:0]  partial_received_r, partial_received_nxt;
  logic [FIELD_W-1:0] partial_length_r,   partial_length_nxt;

  result_t res;
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;

  logic               accept, take;
  logic [ID_W-1:0]    in_id;
  logic               active, bad_hdr, single, first, cont_ok, ovf, done;
  logic [FIELD_W-1:0] idx_u, recv_next;
  logic [FIELD_W-1:0] base_len;
  logic [FRAG_W-1:0]  base_recv, new_recv;
  logic [FIELD_W:0]   sum;

  // Only the leading ID_BYTES characters of the id take part.
  assign in_id  = in_message_id[MSG_ID_W-1 -: ID_W];
  assign active = (partial_total_r != '0);

  assign bad_hdr = (in_fragment_total < 16'sd1)
                || (in_fragment_total > $signed({8'd0, max_frag_r}))
                || (in_fragment_index < 16'sd1)
                || (in_fragment_index > in_fragment_total);
  assign single  = (in_fragment_total == 16'sd1);
  assign first   = (in_fragment_index == 16'sd1);

  assign idx_u     = in_fragment_index;
  assign recv_next = {8'd0, partial_received_r} + 16'd1;
  // Past the header check the total fits in eight bits.
  assign cont_ok   = active && (in_fragment_total[FRAG_W-1:0] == partial_total_r)
                  && (in_id == partial_id_r) && (idx_u == recv_next);

  assign base_len  = first ? '0 : partial_length_r;
  assign base_recv = first ? '0 : partial_received_r;
  assign sum       = {1'b0, base_len} + {1'b0, in_chunk_length};
  assign ovf       = (sum > {1'b0, max_buf_r});
  assign new_recv  = base_recv + 8'd1;
  assign done      = (new_recv == in_fragment_total[FRAG_W-1:0]);

  always_comb begin
    res                  = '0;
    partial_id_nxt       = '0;
    partial_total_nxt    = '0;
    partial_received_nxt = '0;
    partial_length_nxt   = '0;
    if (bad_hdr) begin
      res.verdict         = VERDICT_BAD_HDR;
      res.dropped_partial = active;
    end else if (single) begin
      res.verdict         = VERDICT_SINGLE;
      res.dropped_partial = active;
    end else if (!first && !cont_ok) begin
      res.verdict         = VERDICT_MISMATCH;
      res.dropped_partial = active;
    end else if (ovf) begin
      res.verdict         = VERDICT_OVERFLOW;
      res.dropped_partial = first ? active : 1'b1;
    end else begin
      res.write_offset    = base_len;
      res.dropped_partial = first ? active : 1'b0;
      if (done) begin
        res.verdict        = VERDICT_COMPLETE;
        res.message_length = sum[FIELD_W-1:0];
      end else begin
        res.verdict          = VERDICT_STORED;
        partial_id_nxt       = in_id;
        partial_total_nxt    = in_fragment_total[FRAG_W-1:0];
        partial_received_nxt = new_recv;
        partial_length_nxt   = sum[FIELD_W-1:0];
      end
    end
  end

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign take     = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frag_r <= MAX_FRAGMENTS_RST;
      max_buf_r  <= MAX_BUFFER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_FRAGMENTS: max_frag_r <= cfg_wdata[FRAG_W-1:0];
        CFG_MAX_BUFFER:    max_buf_r  <= cfg_wdata;
        default:           max_frag_r <= max_frag_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_id_r       <= '0;
      partial_total_r    <= '0;
      partial_received_r <= '0;
      partial_length_r   <= '0;
    end else if (accept) begin
      partial_id_r       <= partial_id_nxt;
      partial_total_r    <= partial_total_nxt;
      partial_received_r <= partial_received_nxt;
      partial_length_r   <= partial_length_nxt;
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || take) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_verdict         = out_r.verdict;
  assign out_write_offset    = out_r.write_offset;
  assign out_message_length  = out_r.message_length;
  assign out_dropped_partial = out_r.dropped_partial;

endmodule

>>> rtl/frt_checker.sv
// ----------------------------------------------------------------------------
// frt_checker
// Port-level checks on the result channel of the reassembly tracker.
// ----------------------------------------------------------------------------
module frt_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  frt_pkg::verdict_t           out_verdict,
  input  logic [frt_pkg::FIELD_W-1:0] out_write_offset,
  input  logic [frt_pkg::FIELD_W-1:0] out_message_length,
  input  logic                        out_dropped_partial
);
  import frt_pkg::*;

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict)
      && $stable(out_write_offset) && $stable(out_message_length)
      && $stable(out_dropped_partial))
    else $error("stalled result word changed");

  // Only a completed message reports a length.
  a_length_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict != VERDICT_COMPLETE |-> out_message_length == '0)
    else $error("message length outside a completion");

  // Single and rejected headers never carry a buffer offset.
  a_offset_only_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VERDICT_SINGLE || out_verdict == VERDICT_BAD_HDR
      || out_verdict == VERDICT_MISMATCH || out_verdict == VERDICT_OVERFLOW)
      |-> out_write_offset == '0)
    else $error("offset given for a rejected header");

  // A completion always continues the partial, so nothing is dropped and the
  // final chunk lies inside the message.
  a_complete_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == VERDICT_COMPLETE
      |-> !out_dropped_partial && out_message_length >= out_write_offset)
    else $error("inconsistent completion word");

endmodule

bind fragment_reassembly_tracker_top frt_checker u_frt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_verdict         (out_verdict),
  .out_write_offset    (out_write_offset),
  .out_message_length  (out_message_length),
  .out_dropped_partial (out_dropped_partial)
);

>>> tb/fragment_reassembly_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_top_tb
// Drives fragment headers through the tracker under several limit settings,
// with random idle bursts on both channels in some phases, and checks every
// result word against an in-order predictor of the partial-message bookkeeping.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_top_tb;
  import frt_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          MAX_REPORTS    = 100;
  localparam logic [63:0] ID_MASK        = ~64'd0 << (64 - 8 * ID_BYTES_DEF);

  class reassembly_scoreboard;
    logic [7:0]  max_frags;
    logic [15:0] max_buf;
    logic [63:0] part_id;
    logic [7:0]  part_total;
    logic [7:0]  part_rcvd;
    logic [15:0] part_len;
    result_t     expected_results[$];
    int          errors;
    int          reported;

    function new();
      max_frags = MAX_FRAGMENTS_RST;
      max_buf   = MAX_BUFFER_RST;
      errors    = 0;
      reported  = 0;
      clear_partial();
    endfunction

    function void clear_partial();
      part_id    = '0;
      part_total = '0;
      part_rcvd  = '0;
      part_len   = '0;
    endfunction

    function void apply_register(cfg_reg_t idx, logic [15:0] data);
      case (idx)
        CFG_MAX_FRAGMENTS: max_frags = data[7:0];
        CFG_MAX_BUFFER:    max_buf   = data;
        default: ;
      endcase
    endfunction

    // Works out the verdict for one accepted header and queues it.
    function void note_header(logic [63:0] id_raw, logic signed [15:0] idx,
                              logic signed [15:0] tot, logic [15:0] len);
      int          i_idx;
      int          i_tot;
      logic [63:0] id;
      bit          active;
      bit          ok;
      result_t     r;
      i_idx  = idx;
      i_tot  = tot;
      id     = id_raw & ID_MASK;
      active = (part_total != 0);
      r      = '0;
      r.verdict = VERDICT_SINGLE;
      if (i_tot < 1 || i_tot > int'(max_frags) || i_idx < 1 || i_idx > i_tot) begin
        r.verdict         = VERDICT_BAD_HDR;
        r.dropped_partial = active;
        clear_partial();
      end else if (i_tot == 1) begin
        r.verdict         = VERDICT_SINGLE;
        r.dropped_partial = active;
        clear_partial();
      end else begin
        ok = 1'b1;
        if (i_idx == 1) begin
          r.dropped_partial = active;
          part_id    = id;
          part_total = 8'(i_tot);
          part_rcvd  = '0;
          part_len   = '0;
        end else if (!active || int'(part_total) != i_tot || part_id != id ||
                     i_idx != int'(part_rcvd) + 1) begin
          ok = 1'b0;
          r.dropped_partial = active;
        end
        if (!ok) begin
          r.verdict = VERDICT_MISMATCH;
          clear_partial();
        end else if ({1'b0, part_len} + {1'b0, len} > {1'b0, max_buf}) begin
          // A continuation always loses the partial; a first fragment only
          // loses one if it displaced an older partial above.
          r.verdict = VERDICT_OVERFLOW;
          if (i_idx != 1) r.dropped_partial = 1'b1;
          clear_partial();
        end else begin
          r.write_offset = part_len;
          part_len  = part_len + len;
          part_rcvd = part_rcvd + 8'd1;
          if (part_rcvd < part_total) begin
            r.verdict = VERDICT_STORED;
          end else begin
            r.verdict        = VERDICT_COMPLETE;
            r.message_length = part_len;
            clear_partial();
          end
        end
      end
      expected_results.push_back(r);
    endfunction

    function void report(string field, longint unsigned exp_val, longint unsigned act_val);
      errors++;
      if (reported < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
                 act_val);
        reported++;
      end
    endfunction

    function void check_result(verdict_t v, logic [15:0] off, logic [15:0] len, logic dp);
      result_t e;
      if (expected_results.size() == 0) begin
        report("unexpected result word, verdict", 0, v);
        return;
      end
      e = expected_results.pop_front();
      if (v !== e.verdict) report("verdict", e.verdict, v);
      if (off !== e.write_offset) report("write_offset", e.write_offset, off);
      if (len !== e.message_length) report("message_length", e.message_length, len);
      if (dp !== e.dropped_partial) report("dropped_partial", e.dropped_partial, dp);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  cfg_reg_t            cfg_index;
  logic [15:0]         cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [63:0]         in_message_id;
  logic signed [15:0]  in_fragment_index;
  logic signed [15:0]  in_fragment_total;
  logic [15:0]         in_chunk_length;
  logic                out_valid;
  logic                out_ready;
  verdict_t            out_verdict;
  logic [15:0]         out_write_offset;
  logic [15:0]         out_message_length;
  logic                out_dropped_partial;

  reassembly_scoreboard sb;
  logic [63:0]          id_pool[4];
  bit                   idle_on;
  int                   stall_left;
  int                   idle_cycles;

  fragment_reassembly_tracker_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_message_id       (in_message_id),
    .in_fragment_index   (in_fragment_index),
    .in_fragment_total   (in_fragment_total),
    .in_chunk_length     (in_chunk_length),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_verdict         (out_verdict),
    .out_write_offset    (out_write_offset),
    .out_message_length  (out_message_length),
    .out_dropped_partial (out_dropped_partial)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side stalls at random while idling is enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_header(in_message_id, in_fragment_index, in_fragment_total,
                       in_chunk_length);
      if (out_valid && out_ready)
        sb.check_result(out_verdict, out_write_offset, out_message_length,
                        out_dropped_partial);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the caller must follow with another word or
  // with wait_drained.
  task automatic send_header(logic [63:0] id, logic signed [15:0] idx,
                             logic signed [15:0] tot, logic [15:0] len);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_message_id     <= id;
    in_fragment_index <= idx;
    in_fragment_total <= tot;
    in_chunk_length   <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.apply_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One message sent in order, sometimes with a flaw that breaks it.
  task automatic send_sequence(inout int sent, input int n);
    int          hi;
    int          tot;
    int          per;
    int          flaw_at;
    logic [63:0] id;
    if (sb.max_frags < 2) hi = 2;
    else if ($urandom_range(0, 24) == 0) hi = sb.max_frags;
    else hi = (sb.max_frags < 6) ? int'(sb.max_frags) : 6;
    tot     = $urandom_range(2, hi);
    per     = int'(sb.max_buf) / tot;
    id      = id_pool[$urandom_range(0, 3)];
    flaw_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, tot) : 0;
    for (int k = 1; k <= tot && sent < n; k++) begin
      sent++;
      if (k == flaw_at) begin
        case ($urandom_range(0, 4))
          0: send_header(id, 16'(k + 1), 16'(tot), 16'($urandom_range(0, per)));
          1: send_header(id ^ (64'd1 << $urandom_range(0, 63)), 16'(k), 16'(tot),
                         16'($urandom_range(0, per)));
          2: send_header(id, 16'(k), 16'(tot + 1), 16'($urandom_range(0, per)));
          3: send_header(id, 16'(k), 16'(tot),
                         16'($urandom_range(int'(sb.max_buf), 65535)));
          default: send_header(id, 16'sd1, 16'(tot), 16'($urandom_range(0, per)));
        endcase
        if ($urandom_range(0, 1) == 0) break;
      end else begin
        send_header(id, 16'(k), 16'(tot), 16'($urandom_range(0, per)));
      end
    end
  endtask

  task automatic send_noise();
    int tot;
    case ($urandom_range(0, 2))
      0: send_header({$urandom, $urandom}, 16'($urandom), 16'($urandom), 16'($urandom));
      1: send_header(id_pool[$urandom_range(0, 3)], 16'sd1, 16'sd1, 16'($urandom));
      default: begin
        tot = $urandom_range(1, 10);
        send_header(id_pool[$urandom_range(0, 3)], 16'($urandom_range(0, tot + 1)),
                    16'(tot), 16'($urandom_range(0, 200)));
      end
    endcase
  endtask

  task automatic run_phase(logic [7:0] frags, logic [15:0] buf_bytes, int n, bit idle);
    int sent;
    sent = 0;
    wait_drained();
    idle_on <= idle;
    write_cfg(CFG_MAX_FRAGMENTS, {8'd0, frags});
    write_cfg(CFG_MAX_BUFFER, buf_bytes);
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        send_sequence(sent, n);
      end else begin
        send_noise();
        sent++;
      end
    end
  endtask

  initial begin
    logic [63:0] id_a;
    logic [63:0] id_b;
    sb                = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_MAX_FRAGMENTS;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_message_id     = '0;
    in_fragment_index = '0;
    in_fragment_total = '0;
    in_chunk_length   = '0;
    out_ready         = 1'b0;
    idle_on           = 1'b1;
    stall_left        = 0;
    idle_cycles       = 0;
    id_a              = 64'h0123_4567_89AB_CDEF;
    id_b              = ~id_a;
    id_pool[0]        = {$urandom, $urandom};
    id_pool[1]        = ~id_pool[0];
    id_pool[2]        = {$urandom, $urandom};
    id_pool[3]        = '1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed headers under the reset limits of 8 fragments and 8192 bytes.
    send_header(id_a, 16'sd1, 16'sd1, 16'd0);
    send_header(id_a, 16'sd0, 16'sd3, 16'd5);
    send_header(id_a, -16'sd1, 16'sd3, 16'd5);
    send_header(id_a, 16'sd4, 16'sd3, 16'd5);
    send_header(id_a, 16'sd1, 16'sd0, 16'd5);
    send_header(id_a, 16'sd1, 16'sh8000, 16'd5);
    send_header(id_a, 16'sd1, 16'sd9, 16'd5);
    send_header(id_a, 16'sd2, 16'sd3, 16'd5);
    send_header(id_a, 16'sd1, 16'sd3, 16'd100);
    send_header(id_a, 16'sd2, 16'sd3, 16'd200);
    send_header(id_a, 16'sd3, 16'sd3, 16'hFFFF);
    send_header(id_a, 16'sd1, 16'sd3, 16'd10);
    send_header(id_b, 16'sd2, 16'sd3, 16'd10);
    send_header(id_a, 16'sd1, 16'sd3, 16'd10);
    send_header(id_a, 16'sd3, 16'sd3, 16'd10);
    send_header(id_a, 16'sd1, 16'sd3, 16'd10);
    send_header(id_a, 16'sd2, 16'sd4, 16'd10);
    send_header(id_a, 16'sd1, 16'sd2, 16'd7);
    send_header(id_b, 16'sd1, 16'sd2, 16'd8192);
    send_header(id_b, 16'sd2, 16'sd2, 16'd0);
    send_header(id_a, 16'sd1, 16'sd2, 16'd8193);
    send_header(id_a, 16'sd1, 16'sd8, 16'd1);
    send_header(id_b, 16'sd1, 16'sd4, 16'd9000);
    send_header(id_a, 16'sd1, 16'sd8, 16'd1);
    send_header(id_a, 16'sd1, 16'sd1, 16'd0);
    send_header(id_a, 16'sd1, 16'sd8, 16'd1);
    send_header(64'hFFFF_FFFF_FFFF_FFFF, 16'sd32767, 16'sd32767, 16'hFFFF);
    send_header(64'd0, 16'sd1, 16'sd2, 16'd0);
    send_header(64'd0, 16'sd2, 16'sd2, 16'd0);

    run_phase(8'd8, 16'd8192, 450, 1'b1);
    run_phase(8'd255, 16'd65535, 400, 1'b1);
    run_phase(8'd1, 16'd1, 150, 1'b1);
    // A zero fragment limit turns every header into a bad one.
    run_phase(8'd0, 16'd100, 50, 1'b1);
    run_phase(8'd3, 16'd300, 300, 1'b0);
    run_phase(8'd16, 16'd4096, 400, 1'b0);

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
